[rtl/core/apg_pkg.sv]
// Shared constants, types and formats of the arc point generator.
`timescale 1ns / 1ps
`default_nettype none

package apg_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int NSAT_W     = $clog2(MAX_POINTS + 1);

    localparam int          TURN_W   = 25;
    localparam logic [24:0] TURN_Q16 = 25'd23592960;
    localparam int          DIV_W    = 33;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // phase = floor(r * 2^13 / 45), exact through a rounded-up reciprocal
    localparam longint unsigned DEG_DIV   = 45;
    localparam logic [38:0]     PHASE_MUL = 39'(((64'd1 << 44) + DEG_DIV - 1) / DEG_DIV);

    // one turn is 45 << 19: floor(y / 45) == (y * MOD45_MUL) >> 20 for y below 2^14
    localparam logic [14:0]     MOD45_MUL = 15'(((64'd1 << 20) + DEG_DIV - 1) / DEG_DIV);

    localparam int COS_TERMS = 7;
    localparam int SIN_TERMS = COS_TERMS - 1;

    localparam longint unsigned COS_DIV [COS_TERMS] = '{182, 132, 90, 56, 30, 12, 2};
    localparam longint unsigned SIN_DIV [SIN_TERMS] = '{156, 110, 72, 42, 20, 6};

    localparam int COS_SH [COS_TERMS] = '{
        32 + $clog2(COS_DIV[0]), 32 + $clog2(COS_DIV[1]), 32 + $clog2(COS_DIV[2]),
        32 + $clog2(COS_DIV[3]), 32 + $clog2(COS_DIV[4]), 32 + $clog2(COS_DIV[5]),
        32 + $clog2(COS_DIV[6])};
    localparam int SIN_SH [SIN_TERMS] = '{
        32 + $clog2(SIN_DIV[0]), 32 + $clog2(SIN_DIV[1]), 32 + $clog2(SIN_DIV[2]),
        32 + $clog2(SIN_DIV[3]), 32 + $clog2(SIN_DIV[4]), 32 + $clog2(SIN_DIV[5])};

    // ceil(2^sh / d): floor(p / d) == (p * mul) >> sh for every 32-bit p
    localparam logic [32:0] COS_MUL [COS_TERMS] = '{
        33'(((64'd1 << COS_SH[0]) + COS_DIV[0] - 1) / COS_DIV[0]),
        33'(((64'd1 << COS_SH[1]) + COS_DIV[1] - 1) / COS_DIV[1]),
        33'(((64'd1 << COS_SH[2]) + COS_DIV[2] - 1) / COS_DIV[2]),
        33'(((64'd1 << COS_SH[3]) + COS_DIV[3] - 1) / COS_DIV[3]),
        33'(((64'd1 << COS_SH[4]) + COS_DIV[4] - 1) / COS_DIV[4]),
        33'(((64'd1 << COS_SH[5]) + COS_DIV[5] - 1) / COS_DIV[5]),
        33'(((64'd1 << COS_SH[6]) + COS_DIV[6] - 1) / COS_DIV[6])};
    localparam logic [32:0] SIN_MUL [SIN_TERMS] = '{
        33'(((64'd1 << SIN_SH[0]) + SIN_DIV[0] - 1) / SIN_DIV[0]),
        33'(((64'd1 << SIN_SH[1]) + SIN_DIV[1] - 1) / SIN_DIV[1]),
        33'(((64'd1 << SIN_SH[2]) + SIN_DIV[2] - 1) / SIN_DIV[2]),
        33'(((64'd1 << SIN_SH[3]) + SIN_DIV[3] - 1) / SIN_DIV[3]),
        33'(((64'd1 << SIN_SH[4]) + SIN_DIV[4] - 1) / SIN_DIV[4]),
        33'(((64'd1 << SIN_SH[5]) + SIN_DIV[5] - 1) / SIN_DIV[5])};

    typedef struct packed {
        logic [31:0]      cx;
        logic [31:0]      cy;
        logic [30:0]      radius;
        logic [31:0]      area;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             empty;
    } point_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] area;
        logic [5:0]  idx;
        logic        last;
        logic        empty;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [TURN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [TURN_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/arc_point_generator.sv]
// Arc point generator top level: request sequencer, divider and point pipeline.
//
// Usage: one arc request word enters on the s_ channel (s_tuser = full circle mode).
// The block answers with point_count point words on the m_ channel, m_tlast marking
// the last one; a count below two gives a single word with m_tuser (no points) set.
// Sequence: an arc takes one pass of the shared bit-serial divider for the angle
// step; a full circle first takes a second pass for its end angle. The states
// ST_SMOD and ST_QMOD then reduce the start angle and the step to one turn, and
// one point enters the pipeline per cycle while the receiver does not stall; an
// empty request goes straight to emitting its single word.
// The next request is taken once the last point of the current one enters the
// point pipeline.
// A point runs through the head, series and tail stages in order, a depth set by
// the chain of multiplies for phase, the two nested series and the radius scaling.
// Reset clears the sequencer, the divider and every pipeline valid bit.
// When the receiver stalls, the whole point pipeline holds; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module arc_point_generator (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // center_x[31:0], center_y[63:32], arc_radius[94:64], start_angle[126:95],
    // end_angle[158:127], point_count[165:159], point_area[197:166], zero pad
    input  wire logic [199:0] s_tdata,
    // mode
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // point_x[31:0], point_y[63:32], area_out[95:64], point_index[101:96], zero pad
    output logic [103:0]      m_tdata,
    output logic              m_tlast,
    // no_points
    output logic              m_tuser
);

    localparam int IW = apg_pkg::IDX_W;
    localparam int TW = apg_pkg::TURN_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ENDDIV = 6'b000010,
        ST_QDIV   = 6'b000100,
        ST_SMOD   = 6'b001000,
        ST_QMOD   = 6'b010000,
        ST_EMIT   = 6'b100000
    } seq_state_t;

    // reduce a magnitude modulo one turn: keep the low 19 bits, take the rest mod 45
    function automatic logic [TW-1:0] mod_turn(input logic [32:0] v);
        logic [13:0] hi;
        logic [28:0] prod;
        logic [8:0]  q;
        logic [13:0] qm45;
        logic [13:0] rem45;
        hi    = v[32:19];
        prod  = {15'd0, hi} * {14'd0, apg_pkg::MOD45_MUL};
        q     = prod[28:20];
        qm45  = {5'd0, q} * 14'd45;
        rem45 = hi - qm45;
        return {rem45[5:0], v[18:0]};
    endfunction

    seq_state_t state_reg, state_next;

    logic [31:0]  cx_reg, cy_reg, area_reg, start_reg, end_reg;
    logic [30:0]  rad_reg;
    logic         empty_reg;
    logic [IW-1:0] d_reg, rstep_reg, idx_reg, acc_reg;
    logic [apg_pkg::DIV_W-1:0] qstep_reg;
    logic [TW-1:0] qm_reg, r_reg;

    logic [IW-1:0] idx_next, acc_next;
    logic [TW-1:0] r_next;
    logic [TW-1:0] r_start;

    logic [6:0]   in_count;
    logic [apg_pkg::NSAT_W-1:0] nsat;
    logic         fire_in;

    logic [32:0]  delta, dmag, start_abs;
    logic [IW:0]  rsum;
    logic         carry;
    logic [TW:0]  inc, rpos;
    logic [TW+1:0] rneg;

    apg_pkg::div_req_t div_req;
    apg_pkg::div_rsp_t div_rsp;

    apg_pkg::point_t pt;
    logic         pt_valid, pt_ready, pt_fire;

    apg_pkg::result_t res;

    apg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    apg_trig u_trig (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pt_valid),
        .in_ready   (pt_ready),
        .in_angle   (r_reg),
        .in_point   (pt),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign fire_in  = s_tvalid && s_tready;
    assign in_count = s_tdata[165:159];

    // saturate the count to the point limit
    always_comb
    begin
        if (32'(in_count) > 32'(apg_pkg::MAX_POINTS))
            nsat = apg_pkg::NSAT_W'(apg_pkg::MAX_POINTS);
        else
            nsat = apg_pkg::NSAT_W'(in_count);
    end

    assign delta     = {end_reg[31], end_reg} - {start_reg[31], start_reg};
    assign dmag      = delta[32] ? (33'd0 - delta) : delta;
    assign start_abs = start_reg[31] ? (33'd0 - {start_reg[31], start_reg})
                                     : {1'b0, start_reg};
    assign r_start   = mod_turn(start_abs);

    // divider operands follow the sequencer state
    always_comb
    begin
        div_req.start    = (state_reg inside {ST_ENDDIV, ST_QDIV})
                           && !div_rsp.busy && !div_rsp.done;
        div_req.dividend = '0;
        div_req.divisor  = apg_pkg::TURN_Q16;
        case (state_reg)
            ST_ENDDIV:
            begin
                div_req.dividend = {8'd0, apg_pkg::TURN_Q16};
                div_req.divisor  = TW'(d_reg) + TW'(1);
            end
            ST_QDIV:
            begin
                div_req.dividend = dmag;
                div_req.divisor  = TW'(d_reg);
            end
            default:
                div_req.dividend = '0;
        endcase
    end

    // step to the next point: advance the rounded quotient and the angle mod one turn
    always_comb
    begin
        rsum     = {1'b0, acc_reg} + {1'b0, rstep_reg};
        carry    = rsum >= {1'b0, d_reg};
        acc_next = carry ? IW'(rsum - {1'b0, d_reg}) : IW'(rsum);
        inc      = {1'b0, qm_reg} + (TW+1)'(carry);
        rpos     = {1'b0, r_reg} + inc;
        rneg     = {2'b00, r_reg} - {1'b0, inc};
        if (delta[32])
            r_next = rneg[TW+1] ? TW'(rneg + {2'b00, apg_pkg::TURN_Q16}) : TW'(rneg);
        else
            r_next = (rpos >= {1'b0, apg_pkg::TURN_Q16})
                     ? TW'(rpos - {1'b0, apg_pkg::TURN_Q16}) : TW'(rpos);
        idx_next = idx_reg + IW'(1);
    end

    assign pt_valid  = (state_reg == ST_EMIT);
    assign pt_fire   = pt_valid && pt_ready;
    assign pt.cx     = cx_reg;
    assign pt.cy     = cy_reg;
    assign pt.radius = rad_reg;
    assign pt.area   = area_reg;
    assign pt.idx    = idx_reg;
    assign pt.last   = empty_reg || (idx_reg == d_reg);
    assign pt.empty  = empty_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire_in)
                begin
                    if (in_count < 7'd2)
                        state_next = ST_EMIT;
                    else if (s_tuser)
                        state_next = ST_ENDDIV;
                    else
                        state_next = ST_QDIV;
                end
            end
            ST_ENDDIV:
                if (div_rsp.done) state_next = ST_QDIV;
            ST_QDIV:
                if (div_rsp.done) state_next = ST_SMOD;
            ST_SMOD:
                state_next = ST_QMOD;
            ST_QMOD:
                state_next = ST_EMIT;
            ST_EMIT:
                if (pt_fire && pt.last) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (fire_in)
                begin
                    cx_reg    <= s_tdata[31:0];
                    cy_reg    <= s_tdata[63:32];
                    rad_reg   <= s_tdata[94:64];
                    start_reg <= s_tdata[126:95];
                    end_reg   <= s_tdata[158:127];
                    area_reg  <= s_tdata[197:166];
                    empty_reg <= (in_count < 7'd2);
                    d_reg     <= IW'(nsat - apg_pkg::NSAT_W'(1));
                    idx_reg   <= '0;
                end
            end
            ST_ENDDIV:
            begin
                // full circle: start at zero, end one step short of a turn
                if (div_rsp.done)
                begin
                    start_reg <= '0;
                    end_reg   <= 32'({8'd0, apg_pkg::TURN_Q16} - div_rsp.quotient);
                end
            end
            ST_QDIV:
            begin
                if (div_rsp.done)
                begin
                    qstep_reg <= div_rsp.quotient;
                    rstep_reg <= IW'(div_rsp.remainder);
                end
            end
            ST_SMOD:
            begin
                if (start_reg[31] && r_start != '0)
                    r_reg <= apg_pkg::TURN_Q16 - r_start;
                else
                    r_reg <= r_start;
            end
            ST_QMOD:
            begin
                qm_reg  <= mod_turn(qstep_reg);
                idx_reg <= '0;
                acc_reg <= d_reg >> 1;
            end
            ST_EMIT:
            begin
                if (pt_fire)
                begin
                    idx_reg <= idx_next;
                    acc_reg <= acc_next;
                    r_reg   <= r_next;
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign m_tdata = {2'b00, res.idx, res.area, res.y, res.x};
    assign m_tlast = res.last;
    assign m_tuser = res.empty;

`ifndef SYNTHESIS
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_fire && pt.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last point");

    a_emit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !empty_reg) |->
            ((idx_reg <= d_reg) && (acc_reg < d_reg) && (r_reg < apg_pkg::TURN_Q16)))
        else $error("point counter, rounding remainder or angle out of range");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (!div_rsp.busy && !div_rsp.done))
        else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

[rtl/core/apg_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module apg_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire apg_pkg::div_req_t req,
    output apg_pkg::div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(apg_pkg::DIV_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [apg_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [apg_pkg::TURN_W-1:0]   rem_reg, rem_next;
    logic [apg_pkg::TURN_W-1:0]   dsr_reg, dsr_next;
    logic [apg_pkg::TURN_W:0]     shifted;
    logic                         fits;

    assign shifted = {rem_reg, quo_reg[apg_pkg::DIV_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            quo_next = {quo_reg[apg_pkg::DIV_W-2:0], fits};
            rem_next = fits ? apg_pkg::TURN_W'(shifted - {1'b0, dsr_reg})
                            : apg_pkg::TURN_W'(shifted);
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(apg_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/core/apg_trig.sv]
// Point pipeline: phase, series sine and cosine, scaling and placement.
`timescale 1ns / 1ps
`default_nettype none

module apg_trig (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [apg_pkg::TURN_W-1:0]  in_angle,
    input  wire apg_pkg::point_t             in_point,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output apg_pkg::result_t                 out_result
);

    localparam int NT = apg_pkg::COS_TERMS;
    localparam int NS = 2 * NT;
    localparam logic [62:0] ROUND_Q30 = 63'd536870912;

    function automatic logic [30:0] next_t(input logic [64:0] prod, input int sh);
        logic [64:0] q;
        q = prod >> sh;
        if (q >= {34'd0, apg_pkg::Q30_ONE})
            return '0;
        return apg_pkg::Q30_ONE - q[30:0];
    endfunction

    function automatic logic [31:0] place(input logic [31:0] c, input logic [61:0] prod,
                                          input logic neg);
        logic [62:0] rounded;
        logic [31:0] mag;
        logic [33:0] sum;
        rounded = {1'b0, prod} + ROUND_Q30;
        mag     = rounded[61:30];
        sum     = neg ? {{2{c[31]}}, c} - {2'b00, mag} : {{2{c[31]}}, c} + {2'b00, mag};
        if (!sum[33] && sum[32:31] != 2'b00)
            return 32'h7FFF_FFFF;
        if (sum[33] && sum[32:31] != 2'b11)
            return 32'h8000_0000;
        return sum[31:0];
    endfunction

    logic en;

    // head stages
    logic              v1_reg, v2_reg, v3_reg;
    apg_pkg::point_t   pt1_reg, pt2_reg, pt3_reg;
    logic [63:0]       php1_reg;
    logic [1:0]        quad2_reg, quad3_reg;
    logic [60:0]       xrp2_reg;
    logic [30:0]       xr3_reg;
    logic [61:0]       x2p3_reg;

    // series stages
    logic              sv_w   [NS+1];
    apg_pkg::point_t   spt_w  [NS+1];
    logic [1:0]        sq_w   [NS+1];
    logic [30:0]       sxr_w  [NS+1];
    logic [31:0]       sx2_w  [NS+1];
    logic              sv_reg [NS];
    apg_pkg::point_t   spt_reg[NS];
    logic [1:0]        sq_reg [NS];
    logic [30:0]       sxr_reg[NS];
    logic [31:0]       sx2_reg[NS];

    logic [30:0]       ct [NT+1];
    logic [30:0]       st [NT];
    logic [31:0]       cp_reg [NT];
    logic [64:0]       cm_reg [NT];
    logic [31:0]       sp_reg [NT];
    logic [64:0]       sm_reg [NT-1];
    logic [31:0]       sfin_reg;

    // tail stages
    logic              v18_reg;
    apg_pkg::point_t   pt18_reg;
    logic [61:0]       pxp_reg, pyp_reg;
    logic              xneg_reg, yneg_reg;
    logic [30:0]       c_fin, s_fin, cs, sn;
    logic              cneg, sneg;

    logic              out_valid_reg;
    apg_pkg::result_t  res_reg, res_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt1_reg   <= in_point;
            php1_reg  <= {39'd0, in_angle} * {25'd0, apg_pkg::PHASE_MUL};
            pt2_reg   <= pt1_reg;
            quad2_reg <= php1_reg[62:61];
            xrp2_reg  <= {31'd0, php1_reg[60:31]} * {30'd0, apg_pkg::HALF_PI_Q30};
            pt3_reg   <= pt2_reg;
            quad3_reg <= quad2_reg;
            xr3_reg   <= xrp2_reg[60:30];
            x2p3_reg  <= {31'd0, xrp2_reg[60:30]} * {31'd0, xrp2_reg[60:30]};
        end
    end

    assign sv_w[0]  = v3_reg;
    assign spt_w[0] = pt3_reg;
    assign sq_w[0]  = quad3_reg;
    assign sxr_w[0] = xr3_reg;
    assign sx2_w[0] = x2p3_reg[61:30];

    genvar j, k;
    generate
        for (j = 0; j < NS; j++)
        begin : g_stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sv_reg[j] <= 1'b0;
                else if (en)
                    sv_reg[j] <= sv_w[j];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    spt_reg[j] <= spt_w[j];
                    sq_reg[j]  <= sq_w[j];
                    sxr_reg[j] <= sxr_w[j];
                    sx2_reg[j] <= sx2_w[j];
                end
            end
            assign sv_w[j+1]  = sv_reg[j];
            assign spt_w[j+1] = spt_reg[j];
            assign sq_w[j+1]  = sq_reg[j];
            assign sxr_w[j+1] = sxr_reg[j];
            assign sx2_w[j+1] = sx2_reg[j];
        end

        assign ct[0] = apg_pkg::Q30_ONE;
        assign st[0] = apg_pkg::Q30_ONE;

        for (k = 0; k < NT; k++)
        begin : g_term
            logic [62:0] cprod, sprod;
            assign cprod    = {31'd0, sx2_w[2*k]} * {32'd0, ct[k]};
            assign ct[k+1]  = next_t(cm_reg[k], apg_pkg::COS_SH[k]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cp_reg[k] <= cprod[61:30];
                    cm_reg[k] <= {33'd0, cp_reg[k]} * {32'd0, apg_pkg::COS_MUL[k]};
                end
            end
            if (k < NT - 1)
            begin : g_sin
                assign sprod   = {31'd0, sx2_w[2*k]} * {32'd0, st[k]};
                assign st[k+1] = next_t(sm_reg[k], apg_pkg::SIN_SH[k]);
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        sp_reg[k] <= sprod[61:30];
                        sm_reg[k] <= {33'd0, sp_reg[k]} * {32'd0, apg_pkg::SIN_MUL[k]};
                    end
                end
            end
            else
            begin : g_sfin
                // sine = x times the nested series
                assign sprod = {32'd0, sxr_w[2*k]} * {32'd0, st[k]};
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        sp_reg[k] <= sprod[61:30];
                        sfin_reg  <= sp_reg[k];
                    end
                end
            end
        end
    endgenerate

    assign c_fin = ct[NT];
    assign s_fin = (sfin_reg > {1'b0, apg_pkg::Q30_ONE}) ? apg_pkg::Q30_ONE : sfin_reg[30:0];

    // fold the quadrant into swap and sign
    always_comb
    begin
        case (sq_w[NS])
            2'd0:
            begin
                cs = c_fin; cneg = 1'b0; sn = s_fin; sneg = 1'b0;
            end
            2'd1:
            begin
                cs = s_fin; cneg = 1'b1; sn = c_fin; sneg = 1'b0;
            end
            2'd2:
            begin
                cs = c_fin; cneg = 1'b1; sn = s_fin; sneg = 1'b1;
            end
            default:
            begin
                cs = s_fin; cneg = 1'b0; sn = c_fin; sneg = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v18_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v18_reg       <= sv_w[NS];
            out_valid_reg <= v18_reg;
        end
    end

    always_comb
    begin
        res_next.x     = pt18_reg.empty ? 32'd0 : place(pt18_reg.cx, pxp_reg, xneg_reg);
        res_next.y     = pt18_reg.empty ? 32'd0 : place(pt18_reg.cy, pyp_reg, yneg_reg);
        res_next.area  = pt18_reg.area;
        res_next.idx   = 6'(pt18_reg.idx);
        res_next.last  = pt18_reg.last;
        res_next.empty = pt18_reg.empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt18_reg <= spt_w[NS];
            pxp_reg  <= {31'd0, spt_w[NS].radius} * {31'd0, cs};
            pyp_reg  <= {31'd0, spt_w[NS].radius} * {31'd0, sn};
            xneg_reg <= cneg;
            yneg_reg <= sneg;
            res_reg  <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

endmodule

`default_nettype wire

[tb/tb_arc_point_generator.sv]
// Self-checking testbench for the arc point generator: directed and random arcs.
`timescale 1ns / 1ps
`default_nettype none

module tb_arc_point_generator;

    // Request fields as they travel on the slave side
    typedef struct {
        logic        full_circle;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [30:0] radius;
        logic [31:0] start_deg;
        logic [31:0] end_deg;
        logic [6:0]  count;
        logic [31:0] area;
    } arc_req_t;

    // One point word as seen on the master side
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] area;
        logic [5:0]  idx;
        logic        last;
        logic        empty;
    } point_word_t;

    localparam longint TURN      = 64'd23592960;
    localparam longint unsigned ONE_Q30   = 64'd1073741824;
    localparam longint unsigned HALF_PI   = 64'd1686629713;
    localparam int     MAX_PTS   = 64;
    localparam int     DRAIN_CYC = 200;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    point_word_t expected_points[$];
    int          mismatch_count;
    int          points_seen;
    int          arcs_sent;
    int          empty_seen;
    int          burst_left;
    bit          stall_enable;

    longint unsigned sine_divs[6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned cos_divs[7]  = '{182, 132, 90, 56, 30, 12, 2};

    arc_point_generator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Truncating Q2.30 product
    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // Nested Taylor series, innermost term first; each term clamps at zero
    function automatic longint unsigned taylor_nest(longint unsigned x2, bit want_cos);
        longint unsigned acc;
        longint unsigned p;
        int              terms;
        acc   = ONE_Q30;
        terms = want_cos ? 7 : 6;
        for (int k = 0; k < terms; k++)
        begin
            p   = q30_mul(x2, acc) / (want_cos ? cos_divs[k] : sine_divs[k]);
            acc = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        end
        return acc;
    endfunction

    // Scale by radius with half-up rounding, apply sign, add centre, saturate
    function automatic logic [31:0] offset_coord(logic [31:0] centre, logic [30:0] radius,
                                                 longint unsigned trig, bit neg);
        longint unsigned mag;
        longint          sum;
        mag = ({33'd0, radius} * trig + (64'd1 << 29)) >> 30;
        sum = neg ? longint'($signed(centre)) - longint'(mag)
                  : longint'($signed(centre)) + longint'(mag);
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    // Work out every point word that one arc request produces
    task automatic predict_arc_points(arc_req_t rq);
        longint          n;
        longint          a0;
        longint          a1;
        longint          delta;
        longint unsigned dmag;
        longint unsigned stepv;
        longint          theta;
        longint          red;
        longint unsigned phase;
        longint unsigned xr;
        longint unsigned x2;
        longint unsigned sv;
        longint unsigned cv;
        longint unsigned cs;
        longint unsigned sn;
        bit              cneg;
        bit              sneg;
        point_word_t     pw;
        n = (rq.count > MAX_PTS) ? MAX_PTS : rq.count;
        if (n < 2)
        begin
            pw = '{x: 32'd0, y: 32'd0, area: rq.area, idx: 6'd0, last: 1'b1, empty: 1'b1};
            expected_points.push_back(pw);
            return;
        end
        a0 = $signed(rq.start_deg);
        a1 = $signed(rq.end_deg);
        if (rq.full_circle)
        begin
            a0 = 0;
            a1 = TURN - TURN / n;
        end
        delta = a1 - a0;
        dmag  = (delta < 0) ? -delta : delta;
        for (longint i = 0; i < n; i++)
        begin
            stepv = (dmag * i + (n - 1) / 2) / (n - 1);
            theta = (delta < 0) ? a0 - longint'(stepv) : a0 + longint'(stepv);
            red   = theta % TURN;
            if (red < 0)
                red += TURN;
            phase = (longint'(red) << 32) / TURN;
            xr    = q30_mul(phase & (ONE_Q30 - 1), HALF_PI);
            x2    = q30_mul(xr, xr);
            sv    = q30_mul(xr, taylor_nest(x2, 1'b0));
            cv    = taylor_nest(x2, 1'b1);
            if (sv > ONE_Q30)
                sv = ONE_Q30;
            if (cv > ONE_Q30)
                cv = ONE_Q30;
            case ((phase >> 30) & 3)
                0:       begin cs = cv; cneg = 0; sn = sv; sneg = 0; end
                1:       begin cs = sv; cneg = 1; sn = cv; sneg = 0; end
                2:       begin cs = cv; cneg = 1; sn = sv; sneg = 1; end
                default: begin cs = sv; cneg = 0; sn = cv; sneg = 1; end
            endcase
            pw.x     = offset_coord(rq.cx, rq.radius, cs, cneg);
            pw.y     = offset_coord(rq.cy, rq.radius, sn, sneg);
            pw.area  = rq.area;
            pw.idx   = i[5:0];
            pw.last  = (i == n - 1);
            pw.empty = 1'b0;
            expected_points.push_back(pw);
        end
    endtask

    // Drive one request word; honor burst gaps, wait for the handshake
    task automatic send_arc(arc_req_t rq);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 5);
        end
        burst_left--;
        predict_arc_points(rq);
        s_tvalid <= 1'b1;
        s_tuser  <= rq.full_circle;
        s_tdata  <= {2'b00, rq.area, rq.count, rq.end_deg, rq.start_deg,
                     rq.radius, rq.cy, rq.cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        arcs_sent++;
    endtask

    function automatic arc_req_t make_arc(logic mode, logic [31:0] cx, logic [31:0] cy,
                                          logic [30:0] rad, logic [31:0] a0,
                                          logic [31:0] a1, logic [6:0] n,
                                          logic [31:0] area);
        arc_req_t rq;
        rq = '{full_circle: mode, cx: cx, cy: cy, radius: rad, start_deg: a0,
               end_deg: a1, count: n, area: area};
        return rq;
    endfunction

    function automatic logic [31:0] rand32();
        return $urandom();
    endfunction

    // Field extremes: zero and full radius, saturating centres, area edges
    task automatic test_field_extremes();
        send_arc(make_arc(0, 32'h0, 32'h0, 31'h0, 32'h0, 32'h0, 7'd2, 32'h0));
        send_arc(make_arc(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0,
                          32'h00B4_0000, 7'd3, 32'hFFFF_FFFF));
        send_arc(make_arc(0, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                          32'h00B4_0000, 32'h0168_0000, 7'd3, 32'h5555_AAAA));
        send_arc(make_arc(0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 7'd5, 32'hAAAA_5555));
        send_arc(make_arc(1, 32'h0001_0000, 32'hFFFF_0000, 31'h0064_0000, rand32(),
                          rand32(), 7'd4, 32'h1234_5678));
        send_arc(make_arc(1, 32'h0, 32'h0, 31'h0001_0000, 32'h0, 32'h0, 7'd64, 32'h1));
    endtask

    // Empty requests, count saturation above the limit, full index range
    task automatic test_count_cases();
        send_arc(make_arc(0, rand32(), rand32(), 31'h7FFF_FFFF, rand32(), rand32(),
                          7'd0, 32'hDEAD_BEEF));
        send_arc(make_arc(1, rand32(), rand32(), 31'h1, rand32(), rand32(), 7'd1,
                          32'h0F0F_0F0F));
        send_arc(make_arc(0, 32'h0, 32'h0, 31'h000A_0000, 32'hFFA6_0000, 32'h005A_0000,
                          7'd65, 32'h2));
        send_arc(make_arc(1, 32'h0, 32'h0, 31'h000A_0000, 32'h0, 32'h0, 7'd127, 32'h3));
    endtask

    // Angles past one turn, negative angles and reversed direction
    task automatic test_angle_wrap();
        send_arc(make_arc(0, 32'h0, 32'h0, 31'h0100_0000, 32'h0438_0000, 32'hFBC8_0000,
                          7'd7, 32'h4));
        send_arc(make_arc(0, 32'h0, 32'h0, 31'h0100_0000, 32'hFF4C_0000, 32'h0000_8000,
                          7'd9, 32'h5));
        send_arc(make_arc(0, 32'h0001_0000, 32'h0, 31'h0000_8000, 32'h005A_0000,
                          32'h005A_0000, 7'd2, 32'h6));
        send_arc(make_arc(0, 32'h0, 32'h0, 31'h3FFF_FFFF, 32'h0, 32'h0167_FFFF,
                          7'd6, 32'h7));
    endtask

    // Mostly small well-formed arcs, occasional large counts and wild fields
    task automatic test_random_arcs(int total);
        arc_req_t rq;
        for (int k = 0; k < total; k++)
        begin
            rq.full_circle = 1'($urandom_range(0, 1));
            rq.cx          = ($urandom_range(0, 3) == 0) ? rand32()
                                                         : 32'($signed($urandom_range(0, 4000)) - 2000) << 12;
            rq.cy          = ($urandom_range(0, 3) == 0) ? rand32()
                                                         : 32'($signed($urandom_range(0, 4000)) - 2000) << 12;
            rq.radius      = ($urandom_range(0, 3) == 0) ? 31'(rand32())
                                                         : 31'($urandom_range(0, 31'hFF_FFFF));
            rq.start_deg   = ($urandom_range(0, 3) == 0) ? rand32()
                                                         : 32'($signed($urandom_range(0, 1440)) - 720) << 16;
            rq.end_deg     = ($urandom_range(0, 3) == 0) ? rand32()
                                                         : 32'($signed($urandom_range(0, 1440)) - 720) << 16
                                                           | $urandom_range(0, 16'hFFFF);
            case ($urandom_range(0, 9))
                0:       rq.count = 7'($urandom_range(0, 127));
                1:       rq.count = 7'($urandom_range(0, 1));
                2:       rq.count = 7'($urandom_range(40, 64));
                default: rq.count = 7'($urandom_range(2, 12));
            endcase
            rq.area = rand32();
            send_arc(rq);
        end
    endtask

    // Receiver: stall on its own pattern, with quiet stretches without stalls
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                stall_enable = ~stall_enable;
            m_tready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Compare each accepted point word with the oldest expectation
    initial
    begin
        point_word_t got;
        point_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = '{x: m_tdata[31:0], y: m_tdata[63:32], area: m_tdata[95:64],
                        idx: m_tdata[101:96], last: m_tlast, empty: m_tuser};
                points_seen++;
                if (got.empty)
                    empty_seen++;
                if (expected_points.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected point word x=%h y=%h", got.x, got.y);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.area !== want.area ||
                        got.idx !== want.idx || got.last !== want.last ||
                        got.empty !== want.empty)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: point exp x=%h y=%h a=%h i=%0d l=%b e=%b, got x=%h y=%h a=%h i=%0d l=%b e=%b",
                                     want.x, want.y, want.area, want.idx, want.last, want.empty,
                                     got.x, got.y, got.area, got.idx, got.last, got.empty);
                    end
                end
            end
        end
    end

    // Hard stop: ~270 arcs at worst 64 points, each under stalls, plus divider passes
    initial
    begin
        #2000000;
        $display("FAIL arc_point_generator");
        $finish;
    end

    initial
    begin
        int wait_cyc;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        mismatch_count = 0;
        points_seen    = 0;
        arcs_sent      = 0;
        empty_seen     = 0;
        burst_left     = 0;
        stall_enable   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_count_cases();
        test_angle_wrap();
        test_random_arcs(256);
        s_tvalid <= 1'b0;

        // Drain outstanding points, then let the pipeline settle
        wait_cyc = 0;
        while (expected_points.size() != 0 && wait_cyc < 100000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Covered %0d arc requests, %0d point words checked (%0d empty).",
                 arcs_sent, points_seen, empty_seen);
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("PASS arc_point_generator");
        else
            $display("FAIL arc_point_generator");
        $finish;
    end

endmodule

`default_nettype wire
